/* rtl/rth_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

    // quotient bits resolved by each divider stage
    localparam int unsigned DIV_BITS_PER_STAGE = 2;
    localparam int unsigned QUO_WIDTH          = 8;
    localparam int unsigned DIV_STAGES         = QUO_WIDTH / DIV_BITS_PER_STAGE;

    // hue offsets in two-degree units
    localparam logic [7:0] HUE_OFS_RED_NEG = 8'd180;
    localparam logic [7:0] HUE_OFS_GREEN   = 8'd60;
    localparam logic [7:0] HUE_OFS_BLUE    = 8'd120;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rth_in_t;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] value_level;
        logic [7:0] alpha_out;
    } rth_out_t;

    // facts about the pixel that ride along with the divisions
    typedef struct packed {
        sector_t    sector;
        logic       neg;
        logic       gray;
        logic       black;
        logic [7:0] value;
        logic [7:0] alpha;
    } rth_side_t;

    // after the classify stage
    typedef struct packed {
        logic [7:0] mn;
        logic [7:0] delta;
        logic [7:0] mag;
        rth_side_t  side;
    } rth_cls_t;

    // one restoring division in flight
    typedef struct packed {
        logic [7:0] den;
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] quo;
    } rth_div_t;

    typedef struct packed {
        rth_div_t  sat_div;
        rth_div_t  hue_div;
        rth_side_t side;
    } rth_pipe_t;

endpackage

`default_nettype wire

/* rtl/rth_front.sv */
`timescale 1ns / 1ps
`default_nettype none

// classify stage then dividend scaling stage
module rth_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  rth_pkg::rth_in_t     in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rth_pkg::rth_pipe_t   out_data
);

    logic               cls_valid_reg;
    rth_pkg::rth_cls_t  cls_reg;
    rth_pkg::rth_cls_t  cls_next;
    logic               cls_ready;

    logic               pipe_valid_reg;
    rth_pkg::rth_pipe_t pipe_reg;
    rth_pkg::rth_pipe_t pipe_next;
    logic               pipe_ready;

    logic [7:0] mx;
    logic [7:0] mn;
    logic [8:0] diff;
    logic [15:0] sat_dividend;
    logic [15:0] hue_dividend;

    // classify: max, min, sector and signed numerator
    always_comb
    begin
        mx = in_data.red;
        if (in_data.green > mx)
        begin
            mx = in_data.green;
        end
        if (in_data.blue > mx)
        begin
            mx = in_data.blue;
        end
        mn = in_data.red;
        if (in_data.green < mn)
        begin
            mn = in_data.green;
        end
        if (in_data.blue < mn)
        begin
            mn = in_data.blue;
        end

        if (mx == in_data.red)
        begin
            cls_next.side.sector = rth_pkg::SEC_RED;
            diff = {1'b0, in_data.green} - {1'b0, in_data.blue};
        end
        else if (mx == in_data.green)
        begin
            cls_next.side.sector = rth_pkg::SEC_GREEN;
            diff = {1'b0, in_data.blue} - {1'b0, in_data.red};
        end
        else
        begin
            cls_next.side.sector = rth_pkg::SEC_BLUE;
            diff = {1'b0, in_data.red} - {1'b0, in_data.green};
        end

        cls_next.side.neg   = diff[8];
        cls_next.mag        = diff[8] ? 8'(9'd0 - diff) : diff[7:0];
        cls_next.mn         = mn;
        cls_next.delta      = mx - mn;
        cls_next.side.gray  = (mx == mn);
        cls_next.side.black = (mx == 8'd0);
        cls_next.side.value = mx;
        cls_next.side.alpha = in_data.alpha;
    end

    // scale: 255*min and 30*|num| by shift and subtract
    always_comb
    begin
        sat_dividend = {cls_reg.mn, 8'd0} - {8'd0, cls_reg.mn};
        hue_dividend = {3'd0, cls_reg.mag, 5'd0} - {7'd0, cls_reg.mag, 1'b0};

        pipe_next.side        = cls_reg.side;
        pipe_next.sat_div.den = cls_reg.side.value;
        pipe_next.sat_div.rem = sat_dividend[15:8];
        pipe_next.sat_div.low = sat_dividend[7:0];
        pipe_next.sat_div.quo = 8'd0;
        pipe_next.hue_div.den = cls_reg.delta;
        pipe_next.hue_div.rem = hue_dividend[15:8];
        pipe_next.hue_div.low = hue_dividend[7:0];
        pipe_next.hue_div.quo = 8'd0;
    end

    assign pipe_ready = !pipe_valid_reg || out_ready;
    assign cls_ready  = !cls_valid_reg || pipe_ready;
    assign in_ready   = cls_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg  <= 1'b0;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            if (cls_ready)
            begin
                cls_valid_reg <= in_valid;
            end
            if (pipe_ready)
            begin
                pipe_valid_reg <= cls_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && cls_ready)
        begin
            cls_reg <= cls_next;
        end
        if (cls_valid_reg && pipe_ready)
        begin
            pipe_reg <= pipe_next;
        end
    end

    assign out_valid = pipe_valid_reg;
    assign out_data  = pipe_reg;

endmodule

`default_nettype wire

/* rtl/rth_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

// one stage of the two restoring dividers
module rth_div_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  rth_pkg::rth_pipe_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rth_pkg::rth_pipe_t   out_data
);

    logic               valid_reg;
    rth_pkg::rth_pipe_t data_reg;
    rth_pkg::rth_pipe_t data_next;

    function automatic rth_pkg::rth_div_t div_step(input rth_pkg::rth_div_t d);
        rth_pkg::rth_div_t r;
        logic [8:0]        t;
        r = d;
        t = {d.rem, d.low[7]};
        if (t >= {1'b0, d.den})
        begin
            t     = t - {1'b0, d.den};
            r.quo = {d.quo[6:0], 1'b1};
        end
        else
        begin
            r.quo = {d.quo[6:0], 1'b0};
        end
        r.rem = t[7:0];
        r.low = {d.low[6:0], 1'b0};
        return r;
    endfunction

    always_comb
    begin
        data_next = in_data;
        for (int unsigned k = 0; k < rth_pkg::DIV_BITS_PER_STAGE; k++)
        begin
            data_next.sat_div = div_step(data_next.sat_div);
            data_next.hue_div = div_step(data_next.hue_div);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* rtl/rth_back.sv */
`timescale 1ns / 1ps
`default_nettype none

// sector offset, special cases and output register
module rth_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  rth_pkg::rth_pipe_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rth_pkg::rth_out_t    out_data
);

    logic              valid_reg;
    rth_pkg::rth_out_t data_reg;
    rth_pkg::rth_out_t data_next;
    logic [7:0]        hq;
    logic [7:0]        ofs;

    always_comb
    begin
        hq = in_data.hue_div.quo;
        case (in_data.side.sector)
            rth_pkg::SEC_RED:   ofs = in_data.side.neg ? rth_pkg::HUE_OFS_RED_NEG : 8'd0;
            rth_pkg::SEC_GREEN: ofs = rth_pkg::HUE_OFS_GREEN;
            rth_pkg::SEC_BLUE:  ofs = rth_pkg::HUE_OFS_BLUE;
            default:            ofs = 8'd0;
        endcase

        data_next.hue         = in_data.side.neg ? (ofs - hq) : (ofs + hq);
        data_next.saturation  = 8'd255 - in_data.sat_div.quo;
        data_next.value_level = in_data.side.value;
        data_next.alpha_out   = in_data.side.alpha;
        if (in_data.side.gray)
        begin
            data_next.hue = 8'd0;
        end
        if (in_data.side.black)
        begin
            data_next.saturation = 8'd0;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* rtl/rgb_to_hsv_pixel.sv */
`timescale 1ns / 1ps
`default_nettype none

// rgb_to_hsv_pixel converts one 8-bit RGBA word per clock while the output
// is not stalled into HSV: hue in two-degree units 0..180, saturation
// 0..255 (255 - floor(255*min/max)), value as the largest channel, alpha
// copied through. The block is a 7-stage pipeline (classify, scale, four
// divider stages resolving two quotient bits each, output), and one word
// can enter every cycle while the output is not stalled. The divider
// stages are pipelined restoring dividers for 255*min/max and
// 30*|num|/delta, which both run in lock step. Both sides use valid/ready;
// a stall on the output backs up stage by stage, and in_ready falls only
// when every stage holds a word.
module rgb_to_hsv_pixel (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  rth_pkg::rth_in_t     in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rth_pkg::rth_out_t    out_data
);

    // handshake and word at each divider stage boundary
    logic               div_valid [0:rth_pkg::DIV_STAGES];
    logic               div_ready [0:rth_pkg::DIV_STAGES];
    rth_pkg::rth_pipe_t div_data  [0:rth_pkg::DIV_STAGES];

    // min/max/sector, then dividends for both divisions
    rth_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // saturation and hue quotients, two bits per stage
    for (genvar s = 0; s < rth_pkg::DIV_STAGES; s++)
    begin : g_div
        rth_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[s]),
            .in_ready  (div_ready[s]),
            .in_data   (div_data[s]),
            .out_valid (div_valid[s+1]),
            .out_ready (div_ready[s+1]),
            .out_data  (div_data[s+1])
        );
    end

    // sector offset, gray and black cases, output register
    rth_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[rth_pkg::DIV_STAGES]),
        .in_ready  (div_ready[rth_pkg::DIV_STAGES]),
        .in_data   (div_data[rth_pkg::DIV_STAGES]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
